// ----- rtl/knn3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the three-nearest-neighbour classifier.
// Used by every module in rtl/; depends on nothing else.
package knn3_pkg;

  // Table geometry and coordinate width.
  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 8;
  localparam int PTR_BITS   = $clog2(MAX_POINTS);
  localparam int DIST_BITS  = 2 * COORD_BITS + 1;
  localparam int COUNT_BITS = PTR_BITS + 1;

  // Field widths fixed by the stream format.
  localparam int INDEX_BITS = 4;
  localparam int S_DATA_BITS = 24;
  localparam int M_DATA_BITS = 16;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POINTS_IN_USE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOTE_THRESHOLD = 2'd1;
  localparam logic [COUNT_BITS-1:0] POINTS_RESET    = COUNT_BITS'(15);
  localparam logic [1:0]            THRESHOLD_RESET = 2'd2;
  localparam logic [COUNT_BITS-1:0] MIN_POINTS      = COUNT_BITS'(3);

  // Item kinds carried in tuser.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One stored reference point.
  typedef struct packed {
    logic                  label;
    logic [COORD_BITS-1:0] lon;
    logic [COORD_BITS-1:0] lat;
  } point_t;

  // The three best candidates, closest first.
  typedef struct packed {
    logic [PTR_BITS-1:0] first;
    logic [PTR_BITS-1:0] second;
    logic [PTR_BITS-1:0] third;
    logic [2:0]          labels;
  } top3_t;

  // Query sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/knn3_point_mem.sv -----
`timescale 1ns / 1ps
// Reference point table: one write port, one registered read port.
// Depends on knn3_pkg.
module knn3_point_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [knn3_pkg::PTR_BITS-1:0] wr_addr,
  input  knn3_pkg::point_t              wr_data,
  input  logic [knn3_pkg::PTR_BITS-1:0] rd_addr,
  output knn3_pkg::point_t              rd_data
);

  knn3_pkg::point_t mem [knn3_pkg::MAX_POINTS];

  // Write on a load transfer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read for the scan.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/knn3_dist_unit.sv -----
`timescale 1ns / 1ps
// Shared squared-distance unit: one table entry per cycle, result registered.
// Depends on knn3_pkg.
module knn3_dist_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [knn3_pkg::PTR_BITS-1:0]   in_idx,
  input  knn3_pkg::point_t                in_point,
  input  logic [knn3_pkg::COORD_BITS-1:0] query_lat,
  input  logic [knn3_pkg::COORD_BITS-1:0] query_lon,
  output logic                            out_valid,
  output logic [knn3_pkg::PTR_BITS-1:0]   out_idx,
  output logic                            out_label,
  output logic [knn3_pkg::DIST_BITS-1:0]  out_dist
);

  logic [knn3_pkg::COORD_BITS-1:0]   diff_lat;
  logic [knn3_pkg::COORD_BITS-1:0]   diff_lon;
  logic [2*knn3_pkg::COORD_BITS-1:0] sq_lat;
  logic [2*knn3_pkg::COORD_BITS-1:0] sq_lon;
  logic [knn3_pkg::DIST_BITS-1:0]    dist_next;

  // Absolute differences, two narrow squares and their sum.
  always_comb begin
    diff_lat = (in_point.lat > query_lat) ? in_point.lat - query_lat
                                          : query_lat - in_point.lat;
    diff_lon = (in_point.lon > query_lon) ? in_point.lon - query_lon
                                          : query_lon - in_point.lon;
    sq_lat    = {{knn3_pkg::COORD_BITS{1'b0}}, diff_lat}
              * {{knn3_pkg::COORD_BITS{1'b0}}, diff_lat};
    sq_lon    = {{knn3_pkg::COORD_BITS{1'b0}}, diff_lon}
              * {{knn3_pkg::COORD_BITS{1'b0}}, diff_lon};
    dist_next = {1'b0, sq_lat} + {1'b0, sq_lon};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_idx   <= in_idx;
    out_label <= in_point.label;
    out_dist  <= dist_next;
  end

endmodule

// ----- rtl/knn3_rank3.sv -----
`timescale 1ns / 1ps
// Keeps the three smallest distances seen in a scan, closest first.
// Strict compares keep the lower index on a tie. Depends on knn3_pkg.
module knn3_rank3 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           in_valid,
  input  logic [knn3_pkg::PTR_BITS-1:0]  in_idx,
  input  logic                           in_label,
  input  logic [knn3_pkg::DIST_BITS-1:0] in_dist,
  output knn3_pkg::top3_t                best
);

  logic [2:0]                     held;
  logic [knn3_pkg::DIST_BITS-1:0] dist0, dist1, dist2;
  logic [2:0]                     ins;

  // Which slots the new candidate beats.
  always_comb begin
    ins[0] = !held[0] || (in_dist < dist0);
    ins[1] = !held[1] || (in_dist < dist1);
    ins[2] = !held[2] || (in_dist < dist2);
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= 3'b000;
    end else if (in_valid) begin
      held <= {held[1], held[0], 1'b1};
    end
  end

  // Sorted insertion, shifting worse entries down.
  always_ff @(posedge clk) begin
    if (in_valid && !clear) begin
      if (ins[0]) begin
        dist2 <= dist1;  best.third  <= best.second; best.labels[2] <= best.labels[1];
        dist1 <= dist0;  best.second <= best.first;  best.labels[1] <= best.labels[0];
        dist0 <= in_dist; best.first <= in_idx;      best.labels[0] <= in_label;
      end else if (ins[1]) begin
        dist2 <= dist1;  best.third  <= best.second; best.labels[2] <= best.labels[1];
        dist1 <= in_dist; best.second <= in_idx;     best.labels[1] <= in_label;
      end else if (ins[2]) begin
        dist2 <= in_dist; best.third <= in_idx;      best.labels[2] <= in_label;
      end
    end
  end

endmodule

// ----- rtl/knn3_majority_classifier_core.sv -----
`timescale 1ns / 1ps
// Three-nearest-neighbour majority classifier, top level. A load writes its point
// into the table on transfer. A query scans N entries, one after another, N being
// points_in_use held between 3 and 16, then drains the read and distance stages and
// loads the output register; the next item is taken after that, unless a waiting
// result holds the last state. Synchronous active-high reset sets the registers to
// 15 and 2 and empties the output; the point table is kept.
module knn3_majority_classifier_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream. tdata: entry_index[3:0], latitude[11:4], longitude[19:12],
  // label_bit[20], zero fill. tuser: mode[0].
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [knn3_pkg::S_DATA_BITS-1:0]    s_tdata,
  input  logic [0:0]                          s_tuser,
  // Result stream. tdata: positive[0], nearest_first[4:1],
  // nearest_second[8:5], nearest_third[12:9], zero fill.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [knn3_pkg::M_DATA_BITS-1:0]    m_tdata,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [knn3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [knn3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  knn3_pkg::state_t state, state_next;

  logic [knn3_pkg::COUNT_BITS-1:0] points_in_use;
  logic [1:0]                      vote_threshold;
  logic [knn3_pkg::COUNT_BITS-1:0] count;
  logic [knn3_pkg::PTR_BITS-1:0]   last_idx;

  logic [knn3_pkg::COORD_BITS-1:0] query_lat, query_lon;
  logic [knn3_pkg::PTR_BITS-1:0]   scan_idx;
  logic                            rd_valid;
  logic [knn3_pkg::PTR_BITS-1:0]   rd_idx;
  knn3_pkg::point_t                rd_point;
  knn3_pkg::point_t                wr_point;

  logic                            dist_valid;
  logic [knn3_pkg::PTR_BITS-1:0]   dist_idx;
  logic                            dist_label;
  logic [knn3_pkg::DIST_BITS-1:0]  cand_dist;
  knn3_pkg::top3_t                 best;

  logic                            s_xfer, load_xfer, query_xfer;
  logic                            out_load;
  logic [1:0]                      hits;

  // Input field views.
  logic [knn3_pkg::INDEX_BITS-1:0] in_entry;
  logic [knn3_pkg::COORD_BITS-1:0] in_lat, in_lon;
  logic                            in_label;

  assign in_entry = s_tdata[3:0];
  assign in_lat   = s_tdata[11:4];
  assign in_lon   = s_tdata[19:12];
  assign in_label = s_tdata[20];

  assign s_tready   = (state == knn3_pkg::ST_IDLE);
  assign s_xfer     = s_tvalid && s_tready;
  assign load_xfer  = s_xfer && (s_tuser[0] == knn3_pkg::MODE_LOAD);
  assign query_xfer = s_xfer && (s_tuser[0] == knn3_pkg::MODE_QUERY);
  assign cfg_ready  = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use  <= knn3_pkg::POINTS_RESET;
      vote_threshold <= knn3_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        knn3_pkg::CFG_POINTS_IN_USE:  points_in_use  <= cfg_data;
        knn3_pkg::CFG_VOTE_THRESHOLD: vote_threshold <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Entries searched, held between three and the table depth.
  always_comb begin
    if (points_in_use < knn3_pkg::MIN_POINTS) begin
      count = knn3_pkg::MIN_POINTS;
    end else if (points_in_use > knn3_pkg::COUNT_BITS'(knn3_pkg::MAX_POINTS)) begin
      count = knn3_pkg::COUNT_BITS'(knn3_pkg::MAX_POINTS);
    end else begin
      count = points_in_use;
    end
    last_idx = knn3_pkg::PTR_BITS'(count - 1'b1);
  end

  // Point table.
  assign wr_point = '{label: in_label, lon: in_lon, lat: in_lat};

  knn3_point_mem u_mem (
    .clk     (clk),
    .wr_en   (load_xfer),
    .wr_addr (knn3_pkg::PTR_BITS'(in_entry)),
    .wr_data (wr_point),
    .rd_addr (scan_idx),
    .rd_data (rd_point)
  );

  // Read pipeline tracking and query latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == knn3_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (query_xfer) begin
      query_lat <= in_lat;
      query_lon <= in_lon;
    end
  end

  // Scan address counter.
  always_ff @(posedge clk) begin
    if (rst || query_xfer) begin
      scan_idx <= '0;
    end else if (state == knn3_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  knn3_dist_unit u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .in_point  (rd_point),
    .query_lat (query_lat),
    .query_lon (query_lon),
    .out_valid (dist_valid),
    .out_idx   (dist_idx),
    .out_label (dist_label),
    .out_dist  (cand_dist)
  );

  knn3_rank3 u_rank (
    .clk      (clk),
    .rst      (rst),
    .clear    (query_xfer),
    .in_valid (dist_valid),
    .in_idx   (dist_idx),
    .in_label (dist_label),
    .in_dist  (cand_dist),
    .best     (best)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= knn3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output load.
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      knn3_pkg::ST_IDLE: begin
        if (query_xfer) state_next = knn3_pkg::ST_SCAN;
      end
      knn3_pkg::ST_SCAN: begin
        if (scan_idx == last_idx) state_next = knn3_pkg::ST_DRAIN;
      end
      knn3_pkg::ST_DRAIN: begin
        if (!rd_valid && !dist_valid) state_next = knn3_pkg::ST_FINISH;
      end
      knn3_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = knn3_pkg::ST_IDLE;
        end
      end
      default: state_next = knn3_pkg::ST_IDLE;
    endcase
  end

  // Vote count over the three neighbours.
  assign hits = 2'(best.labels[0]) + 2'(best.labels[1]) + 2'(best.labels[2]);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000,
                  knn3_pkg::INDEX_BITS'(best.third),
                  knn3_pkg::INDEX_BITS'(best.second),
                  knn3_pkg::INDEX_BITS'(best.first),
                  (hits >= vote_threshold)};
    end
  end

  // The three reported neighbours are always distinct entries.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:1] != m_tdata[8:5]) && (m_tdata[8:5] != m_tdata[12:9])
                 && (m_tdata[4:1] != m_tdata[12:9]))
    else $error("duplicate neighbour index in result");

  // A load never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    load_xfer |=> !$rose(m_tvalid))
    else $error("result raised after a load transfer");

  // The scan pipeline is empty whenever new items are taken.
  assert property (@(posedge clk) disable iff (rst)
    (state == knn3_pkg::ST_IDLE) |-> (!rd_valid && !dist_valid))
    else $error("scan pipeline busy while idle");

endmodule
